// ===== hw/rtl/ecsc_pkg.sv =====
// Package: types, constants and coefficient curves of the emission correction block
`timescale 1ns / 1ps
`default_nettype none

package ecsc_pkg;

    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_cfg_index;

    // Particle kinds; every code above KIND_HE3 takes the alpha formula
    localparam t_kind KIND_NEUTRON  = 3'd0;
    localparam t_kind KIND_PROTON   = 3'd1;
    localparam t_kind KIND_DEUTERON = 3'd2;
    localparam t_kind KIND_TRITON   = 3'd3;
    localparam t_kind KIND_HE3      = 3'd4;

    // Register indexes of the configuration port
    localparam t_cfg_index REG_ENERGY_FLOOR = 2'd0;
    localparam t_cfg_index REG_NEUTRON_GAIN = 2'd1;
    localparam t_cfg_index REG_BARRIER_GAIN = 2'd2;

    localparam logic [31:0] ENERGY_FLOOR_RST = 32'd13107;
    localparam logic [15:0] NEUTRON_GAIN_RST = 16'd512;
    localparam logic [15:0] BARRIER_GAIN_RST = 16'd256;

    localparam logic [15:0] A_MIN    = 16'd4096;
    localparam logic [15:0] UNIT     = 16'd60000;
    localparam logic [23:0] P_SCALE  = 24'd15360000;   // 256 * UNIT
    localparam logic [31:0] T0       = 32'd3264175144; // 0.76 in Q32
    localparam logic [33:0] S_OFFSET = 34'd214748364;  // 0.05 in Q32
    localparam logic [23:0] OUT_MAX  = 24'hFFFFFF;
    localparam logic [61:0] T1_NUM   = 62'd11 << 44;   // 2.2 * 2^44 * 5
    localparam logic [61:0] S_NUM    = 62'd53 << 56;   // 2.12 * 2^56 * 25
    // UNIT = 1875 * 2^5; ceil(2^39 / 1875) is exact for any dividend below 2^28
    localparam logic [28:0] U_RECIP  = 29'd293203101;

    // Coefficient curves over Z, units of 1/20000
    function automatic logic [14:0] curve_pk(input logic [6:0] z);
        int zi;
        int v;
        zi = int'(z);
        if (zi <= 10)      v = 8400;
        else if (zi <= 20) v = 8400 + (zi - 10) * 320;
        else if (zi <= 30) v = 11600 + (zi - 20) * 200;
        else if (zi <= 50) v = 13600 + (zi - 30) * 90;
        else if (zi < 70)  v = 15400 + (zi - 50) * 30;
        else               v = 16000;
        return 15'(v);
    endfunction

    function automatic logic [14:0] curve_ak(input logic [6:0] z);
        int zi;
        int v;
        zi = int'(z);
        if (zi <= 10)      v = 13600;
        else if (zi <= 20) v = 13600 + (zi - 10) * 280;
        else if (zi <= 30) v = 16400 + (zi - 20) * 180;
        else if (zi <= 50) v = 18200 + (zi - 30) * 60;
        else if (zi < 70)  v = 19400 + (zi - 50) * 10;
        else               v = 19600;
        return 15'(v);
    endfunction

    function automatic logic [14:0] curve_pc(input logic [6:0] z);
        int zi;
        int v;
        zi = int'(z);
        if (zi <= 10)      v = 10000;
        else if (zi <= 20) v = 10000 - (zi - 10) * 440;
        else if (zi <= 30) v = 5600 - (zi - 20) * 160;
        else if (zi <= 50) v = 4000 - (zi - 30) * 50;
        else if (zi < 70)  v = 3000 - (zi - 50) * 50;
        else               v = 2000;
        return 15'(v);
    endfunction

    function automatic logic [14:0] curve_ac(input logic [6:0] z);
        int zi;
        int v;
        zi = int'(z);
        if (zi <= 30)      v = 2000;
        else if (zi <= 50) v = 2000 - (zi - 30) * 20;
        else if (zi <= 70) v = 1600 + (zi - 50) * 20;
        else               v = 1200;
        return 15'(v);
    endfunction

    // C coefficient in units of 1/60000, including the unit term
    function automatic logic [16:0] coef_c(input t_kind kind, input logic [6:0] z);
        int pc;
        int ac;
        int v;
        pc = int'(curve_pc(z));
        ac = int'(curve_ac(z));
        case (kind)
            KIND_PROTON:   v = 60000 + 3 * pc;
            KIND_DEUTERON: v = 60000 + (3 * pc) / 2;
            KIND_TRITON:   v = 60000 + pc;
            KIND_HE3:      v = 60000 + 4 * ac;
            default:       v = 60000 + 3 * ac;
        endcase
        return 17'(v);
    endfunction

    // K coefficient in units of 1/60000
    function automatic logic [15:0] coef_k(input t_kind kind, input logic [6:0] z);
        int pk;
        int ak;
        int v;
        pk = int'(curve_pk(z));
        ak = int'(curve_ak(z));
        case (kind)
            KIND_PROTON:   v = 3 * pk;
            KIND_DEUTERON: v = 3 * (pk + 1200);
            KIND_TRITON:   v = 3 * (pk + 2400);
            KIND_HE3:      v = 3 * (ak - 1200);
            default:       v = 3 * ak;
        endcase
        return 16'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ecsc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage
`timescale 1ns / 1ps
`default_nettype none

module ecsc_div #(
    parameter int DW = 16,
    parameter int SW = 16,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [SW-1:0] i_num,
    input  wire logic [PW-1:0] i_side,
    output logic               o_valid,
    output logic [SW-1:0]      o_quo,
    output logic [PW-1:0]      o_side
);

    logic          r_valid [SW];
    logic [DW-1:0] r_den   [SW];
    logic [DW-1:0] r_rem   [SW];
    logic [SW-1:0] r_num   [SW];
    logic [SW-1:0] r_quo   [SW];
    logic [PW-1:0] r_side  [SW];

    for (genvar g = 0; g < SW; g++) begin : g_stage
        logic          w_valid;
        logic [DW-1:0] w_den;
        logic [DW-1:0] w_rem;
        logic [SW-1:0] w_num;
        logic [SW-1:0] w_quo;
        logic [PW-1:0] w_side;
        logic [DW:0]   n_shift;
        logic [DW:0]   n_diff;
        logic          n_take;

        if (g == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_den   = i_den;
            assign w_rem   = i_rem;
            assign w_num   = i_num;
            assign w_quo   = '0;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[g-1];
            assign w_den   = r_den[g-1];
            assign w_rem   = r_rem[g-1];
            assign w_num   = r_num[g-1];
            assign w_quo   = r_quo[g-1];
            assign w_side  = r_side[g-1];
        end

        // Shift in the next numerator bit, subtract the divisor if it fits
        assign n_shift = {w_rem, w_num[SW-1]};
        assign n_diff  = n_shift - {1'b0, w_den};
        assign n_take  = (n_shift >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_adv) begin
                r_valid[g] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_den[g]  <= w_den;
                r_rem[g]  <= n_take ? n_diff[DW-1:0] : n_shift[DW-1:0];
                r_num[g]  <= w_num << 1;
                r_quo[g]  <= {w_quo[SW-2:0], n_take};
                r_side[g] <= w_side;
            end
        end
    end

    assign o_valid = r_valid[SW-1];
    assign o_quo   = r_quo[SW-1];
    assign o_side  = r_side[SW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/emission_cross_section_correction.sv =====
// Emission cross-section correction. Throughput: one beat per cycle while the output
// is not stalled; the depth is set by two chained bit-serial divider pipelines
// (62 stages, then 34 + ENERGY_FRAC_BITS stages).
// A stalled output beat freezes the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module emission_cross_section_correction #(
    parameter int ENERGY_FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Item input
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire ecsc_pkg::t_kind       i_particle_kind,
    input  wire logic [6:0]            i_charge_number,
    input  wire logic [15:0]           i_mass_cube_root,
    input  wire logic [23:0]           i_coulomb_barrier,
    input  wire logic [31:0]           i_kinetic_energy,
    // Result output
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [23:0]                o_correction,
    // Configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire ecsc_pkg::t_cfg_index  i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);

    import ecsc_pkg::*;

    localparam int T2W  = 34 + ENERGY_FRAC_BITS;
    localparam int SUMW = T2W + 1;
    localparam int HIW  = SUMW - 24;

    logic adv;

    logic [31:0] r_energy_floor;
    logic [15:0] r_neutron_gain;
    logic [15:0] r_barrier_gain;

    // Whole pipeline moves unless the output beat is held
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_floor <= ENERGY_FLOOR_RST;
            r_neutron_gain <= NEUTRON_GAIN_RST;
            r_barrier_gain <= BARRIER_GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENERGY_FLOOR: r_energy_floor <= i_cfg_data;
                REG_NEUTRON_GAIN: r_neutron_gain <= i_cfg_data[15:0];
                REG_BARRIER_GAIN: r_barrier_gain <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Stage A: floor the energy, clamp the mass root
    logic        r_a_valid;
    t_kind       r_a_kind;
    logic [6:0]  r_a_z;
    logic [15:0] r_a_a;
    logic [23:0] r_a_cb;
    logic [31:0] r_a_e;
    logic [31:0] n_a_floored;

    assign n_a_floored = (i_kinetic_energy < r_energy_floor) ? r_energy_floor
                                                               : i_kinetic_energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_kind <= i_particle_kind;
            r_a_z    <= i_charge_number;
            r_a_a    <= (i_mass_cube_root < A_MIN) ? A_MIN : i_mass_cube_root;
            r_a_cb   <= i_coulomb_barrier;
            r_a_e    <= (n_a_floored == 32'd0) ? 32'd1 : n_a_floored;
        end
    end

    // Stage B: coefficients, a^2, 5a and the scaled energy P
    logic        r_b_valid;
    t_kind       r_b_kind;
    logic [16:0] r_b_c;
    logic [15:0] r_b_k;
    logic [31:0] r_b_asq;
    logic [18:0] r_b_five_a;
    logic [55:0] r_b_p;
    logic [23:0] r_b_cb;
    logic [31:0] r_b_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_kind   <= r_a_kind;
            r_b_c      <= coef_c(r_a_kind, r_a_z);
            r_b_k      <= coef_k(r_a_kind, r_a_z);
            r_b_asq    <= 32'(r_a_a) * 32'(r_a_a);
            r_b_five_a <= (19'(r_a_a) << 2) + 19'(r_a_a);
            r_b_p      <= 56'(r_a_e) * 56'(P_SCALE);
            r_b_cb     <= r_a_cb;
            r_b_e      <= r_a_e;
        end
    end

    // Stage C: 25 a^2 and barrier gain times K
    logic        r_c_valid;
    t_kind       r_c_kind;
    logic [16:0] r_c_c;
    logic [36:0] r_c_d25;
    logic [31:0] r_c_bk;
    logic [18:0] r_c_five_a;
    logic [55:0] r_c_p;
    logic [23:0] r_c_cb;
    logic [31:0] r_c_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_kind   <= r_b_kind;
            r_c_c      <= r_b_c;
            r_c_d25    <= 37'(r_b_asq) * 37'd25;
            r_c_bk     <= 32'(r_barrier_gain) * 32'(r_b_k);
            r_c_five_a <= r_b_five_a;
            r_c_p      <= r_b_p;
            r_c_cb     <= r_b_cb;
            r_c_e      <= r_b_e;
        end
    end

    // Stage D: barrier term Q
    logic        r_d_valid;
    t_kind       r_d_kind;
    logic [16:0] r_d_c;
    logic [36:0] r_d_d25;
    logic [55:0] r_d_q;
    logic [18:0] r_d_five_a;
    logic [55:0] r_d_p;
    logic [31:0] r_d_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_kind   <= r_c_kind;
            r_d_c      <= r_c_c;
            r_d_d25    <= r_c_d25;
            r_d_q      <= 56'(r_c_bk) * 56'(r_c_cb);
            r_d_five_a <= r_c_five_a;
            r_d_p      <= r_c_p;
            r_d_e      <= r_c_e;
        end
    end

    // Stage E: P - Q and the zero flag for a barrier at or above P
    logic        r_e_valid;
    t_kind       r_e_kind;
    logic [16:0] r_e_c;
    logic [36:0] r_e_d25;
    logic [55:0] r_e_rem;
    logic        r_e_izero;
    logic [18:0] r_e_five_a;
    logic [55:0] r_e_p;
    logic [31:0] r_e_e;
    logic        n_e_izero;

    assign n_e_izero = (r_d_q >= r_d_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (adv) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_kind   <= r_d_kind;
            r_e_c      <= r_d_c;
            r_e_d25    <= r_d_d25;
            r_e_rem    <= n_e_izero ? 56'd0 : (r_d_p - r_d_q);
            r_e_izero  <= n_e_izero;
            r_e_five_a <= r_d_five_a;
            r_e_p      <= r_d_p;
            r_e_e      <= r_d_e;
        end
    end

    // First divider bank: (P-Q)/P fraction, 2.12/a^2 and 2.2/a, in lockstep
    logic        ion_valid;
    logic [61:0] ion_quo;
    logic [3:0]  ion_side;
    logic        s_valid;
    logic [61:0] s_quo;
    logic [31:0] s_side;
    logic        t1_valid;
    logic [61:0] t1_quo;
    logic [16:0] t1_side;

    ecsc_div #(.DW(56), .SW(62), .PW(4)) u_div_ion (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_e_valid),
        .i_den   (r_e_p),
        .i_rem   (r_e_rem),
        .i_num   (62'd0),
        .i_side  ({r_e_kind, r_e_izero}),
        .o_valid (ion_valid),
        .o_quo   (ion_quo),
        .o_side  (ion_side)
    );

    ecsc_div #(.DW(37), .SW(62), .PW(32)) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_e_valid),
        .i_den   (r_e_d25),
        .i_rem   (37'd0),
        .i_num   (S_NUM),
        .i_side  (r_e_e),
        .o_valid (s_valid),
        .o_quo   (s_quo),
        .o_side  (s_side)
    );

    ecsc_div #(.DW(19), .SW(62), .PW(17)) u_div_t1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_e_valid),
        .i_den   (r_e_five_a),
        .i_rem   (19'd0),
        .i_num   (T1_NUM),
        .i_side  (r_e_c),
        .o_valid (t1_valid),
        .o_quo   (t1_quo),
        .o_side  (t1_side)
    );

    // Stage F: signed s - 0.05 as sign and magnitude, t0 + t1, and C times T
    logic        r_f_valid;
    t_kind       r_f_kind;
    logic        r_f_izero;
    logic [48:0] r_f_ct;
    logic        r_f_neg;
    logic [33:0] r_f_mag;
    logic [34:0] r_f_pos;
    logic [31:0] r_f_e;
    logic        n_f_neg;

    assign n_f_neg = (s_quo[33:0] < S_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (adv) begin
            r_f_valid <= ion_valid & s_valid & t1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_kind  <= ion_side[3:1];
            r_f_izero <= ion_side[0];
            r_f_ct    <= 49'(t1_side) * 49'(ion_quo[61:30]);
            r_f_neg   <= n_f_neg;
            r_f_mag   <= n_f_neg ? (S_OFFSET - s_quo[33:0]) : (s_quo[33:0] - S_OFFSET);
            r_f_pos   <= 35'(T0) + 35'(t1_quo[33:0]);
            r_f_e     <= s_side;
        end
    end

    // Second divider bank: |s - 0.05| / e for neutrons; kind, zero flag and C*T ride alongside
    logic            t2_valid;
    logic [T2W-1:0]  t2_quo;
    logic [88:0]     t2_side;

    ecsc_div #(.DW(32), .SW(T2W), .PW(89)) u_div_t2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_f_valid),
        .i_den   (r_f_e),
        .i_rem   (32'd0),
        .i_num   (T2W'(r_f_mag) << ENERGY_FRAC_BITS),
        .i_side  ({r_f_kind, r_f_izero, r_f_ct, r_f_neg, r_f_pos}),
        .o_valid (t2_valid),
        .o_quo   (t2_quo),
        .o_side  (t2_side)
    );

    // Stage H: neutron sum clamped at zero, (C*T >> 21) times the reciprocal of 1875
    logic            r_h_valid;
    t_kind           r_h_kind;
    logic            r_h_izero;
    logic [SUMW-1:0] r_h_sum;
    logic [56:0]     r_h_prod;
    logic [SUMW-1:0] n_h_pos;
    logic [SUMW-1:0] n_h_t2;

    assign n_h_pos = SUMW'(t2_side[34:0]);
    assign n_h_t2  = SUMW'(t2_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (adv) begin
            r_h_valid <= t2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h_kind  <= t2_side[88:86];
            r_h_izero <= t2_side[85];
            if (!t2_side[35]) begin
                r_h_sum <= n_h_pos + n_h_t2;
            end else if (n_h_t2 >= n_h_pos) begin
                r_h_sum <= '0;
            end else begin
                r_h_sum <= n_h_pos - n_h_t2;
            end
            r_h_prod <= 57'(t2_side[84:57]) * 57'(U_RECIP);
        end
    end

    // Stage I: neutron gain in two partial products, ion quotient (below 2^18)
    logic              r_i_valid;
    t_kind             r_i_kind;
    logic [HIW+15:0]   r_i_hi;
    logic [15:0]       r_i_lo;
    logic [23:0]       r_i_ion;
    logic [39:0]       n_i_lo;

    assign n_i_lo = 40'(r_h_sum[23:0]) * 40'(r_neutron_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (adv) begin
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_i_kind <= r_h_kind;
            r_i_hi   <= (HIW+16)'(r_h_sum[SUMW-1:24]) * (HIW+16)'(r_neutron_gain);
            r_i_lo   <= n_i_lo[39:24];
            r_i_ion  <= r_h_izero ? 24'd0 : 24'(r_h_prod[56:39]);
        end
    end

    // Output stage: combine, saturate, select by kind
    logic            r_out_valid;
    logic [23:0]     r_out_corr;
    logic [HIW+16:0] n_o_tot;
    logic [23:0]     n_o_neutron;

    assign n_o_tot     = (HIW+17)'(r_i_hi) + (HIW+17)'(r_i_lo);
    assign n_o_neutron = (|n_o_tot[HIW+16:24]) ? OUT_MAX : n_o_tot[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_corr <= (r_i_kind == KIND_NEUTRON) ? n_o_neutron : r_i_ion;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_correction = r_out_corr;

endmodule

`default_nettype wire
